// ===== src/pcm_to_stereo16_converter_unit_defines.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef PCM_TO_STEREO16_CONVERTER_UNIT_DEFINES_SVH
`define PCM_TO_STEREO16_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCM16_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCM16_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcm16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcm16_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd1;
  localparam logic [1:0] CFG_OFFSET_BINARY = 2'd2;

  // Sample format codes; the code is also the index of the last byte
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  localparam logic [1:0] CH_STEREO = 2'd2;

  localparam logic [7:0]  U8_MID   = 8'h80;
  localparam logic [15:0] SMP_MAX  = 16'h7FFF;
  localparam logic [15:0] SMP_MIN  = 16'h8000;
  localparam logic [15:0] SMP_ZERO = 16'h0000;
  localparam logic [15:0] OFS_BIT  = 16'h8000;

  // Float path: right shift of the rounded 24-bit product is 136 - top - exponent
  localparam logic [7:0]         EXP_MAX        = 8'hFF;
  localparam logic [7:0]         EXP_ZERO       = 8'h00;
  localparam logic signed [9:0]  F2S_SHIFT_BASE = 10'sd136;
  localparam logic signed [9:0]  F2S_SAT_MAX    = 10'sd8;
  localparam logic signed [9:0]  F2S_ZERO_MIN   = 10'sd25;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  fmt;
    logic        offset;
    logic        mono;
    logic        right;
  } pcm16_smp_t;

endpackage

`default_nettype wire

// ===== src/pcm16_f2s.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcm16_f2s (
  input  logic [31:0] word_i,
  output logic [15:0] sample_o
);

  logic               sgn;
  logic [7:0]         ex;
  logic [22:0]        man;
  logic [23:0]        sig;
  logic [38:0]        prod;
  logic               top;
  logic [23:0]        q0;
  logic               guard;
  logic               sticky;
  logic               up;
  logic [24:0]        q;
  logic signed [9:0]  n;
  logic [24:0]        shifted;
  logic [15:0]        mag;

  assign sgn  = word_i[31];
  assign ex   = word_i[30:23];
  assign man  = word_i[22:0];
  assign sig  = {1'b1, man};
  // sig * 32767 as sig * 32768 - sig
  assign prod = {sig, 15'd0} - {15'd0, sig};
  assign top  = prod[38];

  always_comb begin
    if (top) begin
      q0     = prod[38:15];
      guard  = prod[14];
      sticky = |prod[13:0];
    end else begin
      q0     = prod[37:14];
      guard  = prod[13];
      sticky = |prod[12:0];
    end
  end

  // round to nearest, ties to even
  assign up      = guard & (sticky | q0[0]);
  assign q       = {1'b0, q0} + {24'd0, up};
  assign n       = pcm16_pkg::F2S_SHIFT_BASE - $signed({9'd0, top})
                   - $signed({2'b00, ex});
  assign shifted = q >> n[4:0];
  assign mag     = shifted[15:0];

  always_comb begin
    if (ex == pcm16_pkg::EXP_MAX) begin
      if (man != 23'd0) begin
        sample_o = pcm16_pkg::SMP_ZERO;
      end else begin
        sample_o = sgn ? pcm16_pkg::SMP_MIN : pcm16_pkg::SMP_MAX;
      end
    end else if (ex == pcm16_pkg::EXP_ZERO) begin
      // zero and subnormals are far below one step
      sample_o = pcm16_pkg::SMP_ZERO;
    end else if (n <= pcm16_pkg::F2S_SAT_MAX) begin
      sample_o = sgn ? pcm16_pkg::SMP_MIN : pcm16_pkg::SMP_MAX;
    end else if (n >= pcm16_pkg::F2S_ZERO_MIN) begin
      sample_o = pcm16_pkg::SMP_ZERO;
    end else if (sgn) begin
      sample_o = 16'd0 - mag;
    end else if (mag > pcm16_pkg::SMP_MAX) begin
      sample_o = pcm16_pkg::SMP_MAX;
    end else begin
      sample_o = mag;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcm16_asm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcm16_asm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic [1:0]           channel_count_i,
  input  logic [1:0]           sample_format_i,
  input  logic                 offset_binary_i,
  output logic                 smp_valid_o,
  input  logic                 smp_ready_i,
  output pcm16_pkg::pcm16_smp_t smp_o
);

  logic [1:0]            pos_q, pos_d;
  logic [23:0]           held_q, held_d;
  logic                  chan_q, chan_d;
  logic                  smp_valid_q, smp_valid_d;
  pcm16_pkg::pcm16_smp_t smp_q, smp_d;
  logic                  accept;
  logic                  done;
  logic                  mono;

  assign in_ready_o = !smp_valid_q || smp_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign done       = pos_q >= sample_format_i;
  assign mono       = channel_count_i != pcm16_pkg::CH_STEREO;

  always_comb begin
    pos_d       = pos_q;
    held_d      = held_q;
    chan_d      = chan_q;
    smp_valid_d = smp_valid_q && !smp_ready_i;
    smp_d       = smp_q;
    if (accept) begin
      if (!done) begin
        case (pos_q)
          2'd0: begin
            held_d[7:0] = data_byte_i;
          end
          2'd1: begin
            held_d[15:8] = data_byte_i;
          end
          default: begin
            held_d[23:16] = data_byte_i;
          end
        endcase
        pos_d = pos_q + 2'd1;
      end else begin
        // sample complete: hand the word on and start over
        pos_d        = 2'd0;
        held_d       = 24'd0;
        smp_valid_d  = 1'b1;
        smp_d.word   = {data_byte_i, held_q};
        smp_d.fmt    = sample_format_i;
        smp_d.offset = offset_binary_i;
        smp_d.mono   = mono;
        smp_d.right  = mono ? 1'b0 : chan_q;
        chan_d       = mono ? 1'b0 : !chan_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      held_q      <= 24'd0;
      chan_q      <= 1'b0;
      smp_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      held_q      <= held_d;
      chan_q      <= chan_d;
      smp_valid_q <= smp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign smp_valid_o = smp_valid_q;
  assign smp_o       = smp_q;

endmodule

`default_nettype wire

// ===== src/pcm16_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcm16_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  smp_valid_i,
  output logic                  smp_ready_o,
  input  pcm16_pkg::pcm16_smp_t smp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           sample_value_o,
  output logic                  right_channel_o,
  output logic                  last_of_run_o
);

  logic        out_valid_q, out_valid_d;
  logic        dup_q, dup_d;
  logic [15:0] sample_q, sample_d;
  logic        right_q, right_d;
  logic        last_q, last_d;
  logic        out_free;
  logic [15:0] f32_val;
  logic [15:0] conv;

  pcm16_f2s u_f2s (
    .word_i   (smp_i.word),
    .sample_o (f32_val)
  );

  always_comb begin
    case (smp_i.fmt)
      pcm16_pkg::FMT_U8: begin
        conv = {pcm16_pkg::U8_MID - smp_i.word[31:24], 8'h00};
      end
      pcm16_pkg::FMT_S16: begin
        conv = {smp_i.word[31:24], smp_i.word[7:0]};
      end
      pcm16_pkg::FMT_S24: begin
        conv = {smp_i.word[31:24], smp_i.word[15:8]};
      end
      default: begin
        conv = f32_val;
      end
    endcase
    // adding 32768 mod 65536 flips the top bit
    if (smp_i.fmt != pcm16_pkg::FMT_U8 && smp_i.offset) begin
      conv = conv ^ pcm16_pkg::OFS_BIT;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign smp_ready_o = out_free && !dup_q;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    dup_d       = dup_q;
    sample_d    = sample_q;
    right_d     = right_q;
    last_d      = last_q;
    if (out_free) begin
      if (dup_q) begin
        // mono: repeat the left word as the right one
        out_valid_d = 1'b1;
        right_d     = 1'b1;
        last_d      = 1'b1;
        dup_d       = 1'b0;
      end else if (smp_valid_i) begin
        out_valid_d = 1'b1;
        sample_d    = conv;
        right_d     = smp_i.right;
        last_d      = !smp_i.mono;
        dup_d       = smp_i.mono;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dup_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      dup_q       <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    right_q  <= right_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign sample_value_o  = sample_q;
  assign right_channel_o = right_q;
  assign last_of_run_o   = last_q;

endmodule

`default_nettype wire

// ===== src/pcm_to_stereo16_converter_unit.sv =====
// Little-endian PCM byte stream in, interleaved 16-bit stereo words out.
// Input channel: one byte per word on data_byte_i, valid/ready handshake.
// Output channel: sample_value_o with right_channel_o and last_of_run_o,
// valid/ready handshake. Mono samples go out twice, left then right.
// Configuration: write channel_count, sample_format and offset_binary through
// cfg_we_i/cfg_index_i/cfg_data_i while the block is idle; no read-back.
// The result of a byte that completes a sample is registered in the assembly
// register, then in the output register, before it is valid on the output.
// Bytes that do not complete a sample produce nothing.
// Throughput: one byte per cycle in stereo while the receiver is ready; in mono
// a completing byte waits for the right copy: one word per cycle goes out.
// A stalled receiver holds the output register, then the assembly register,
// and then in_ready_o drops; nothing is lost or repeated.
// Reset clears the byte position, held bytes, channel position and both
// valid flags; configuration returns to mono, 8-bit, no offset.
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_to_stereo16_converter_unit_defines.svh"

module pcm_to_stereo16_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] sample_value_o,
  output logic        right_channel_o,
  output logic        last_of_run_o
);

  logic [1:0]            channel_count_q;
  logic [1:0]            sample_format_q;
  logic                  offset_binary_q;
  logic                  smp_valid;
  logic                  smp_ready;
  pcm16_pkg::pcm16_smp_t smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= 2'd1;
      sample_format_q <= pcm16_pkg::FMT_U8;
      offset_binary_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pcm16_pkg::CFG_CHANNEL_COUNT: begin
          channel_count_q <= cfg_data_i;
        end
        pcm16_pkg::CFG_SAMPLE_FORMAT: begin
          sample_format_q <= cfg_data_i;
        end
        pcm16_pkg::CFG_OFFSET_BINARY: begin
          offset_binary_q <= cfg_data_i[0];
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  pcm16_asm u_asm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .channel_count_i (channel_count_q),
    .sample_format_i (sample_format_q),
    .offset_binary_i (offset_binary_q),
    .smp_valid_o     (smp_valid),
    .smp_ready_i     (smp_ready),
    .smp_o           (smp)
  );

  pcm16_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .smp_valid_i     (smp_valid),
    .smp_ready_o     (smp_ready),
    .smp_i           (smp),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_value_o  (sample_value_o),
    .right_channel_o (right_channel_o),
    .last_of_run_o   (last_of_run_o)
  );

  `PCM16_ASSERT_IMP(a_first_is_left, out_valid_o && !last_of_run_o, !right_channel_o, "non-last word not left")
  `PCM16_ASSERT_NXT(a_mono_right_follows, out_valid_o && out_ready_i && !last_of_run_o, out_valid_o && right_channel_o && last_of_run_o, "mono right word missing")
  `PCM16_ASSERT_NXT(a_mono_same_value, out_valid_o && out_ready_i && !last_of_run_o, sample_value_o == $past(sample_value_o), "mono pair values differ")

endmodule

`default_nettype wire
